>>> design/i2c_dwe_pkg.sv
package i2c_dwe_pkg;

  localparam int AddrWidth  = 8;
  localparam int PhaseWidth = 16;
  localparam int TimerWidth = PhaseWidth + 1;
  localparam int ByteWidth  = 8;
  localparam int ApbAddrWidth = 3;
  localparam int ApbDataWidth = 32;

  localparam logic [AddrWidth-1:0]  ADDR_RESET   = 8'h78;
  localparam logic [PhaseWidth-1:0] PHASE_RESET  = 16'd1;
  localparam logic [ByteWidth-1:0]  CTRL_COMMAND = 8'h00;
  localparam logic [ByteWidth-1:0]  CTRL_DATA    = 8'h40;

  // Bit slot of the acknowledge pulse that closes each byte
  localparam logic [3:0] ACK_SLOT  = 4'd8;
  // Byte slots in the order they go out
  localparam logic [1:0] SLOT_ADDR = 2'd0;
  localparam logic [1:0] SLOT_CTRL = 2'd1;
  localparam logic [1:0] SLOT_PAYLOAD = 2'd2;

  // Register index as decoded from paddr[2]
  localparam logic REG_SLAVE_ADDRESS = 1'b0;
  localparam logic REG_PHASE_TICKS   = 1'b1;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START_A,
    SEQ_START_B,
    SEQ_BIT_LOW,
    SEQ_BIT_HIGH,
    SEQ_STOP_A,
    SEQ_STOP_B,
    SEQ_STOP_C
  } seq_step_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  slave_address;
    logic [PhaseWidth-1:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic accepted;
    logic done_res;
  } res_t;

endpackage

>>> design/i2c_dwe_if.sv
interface i2c_dwe_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       is_data;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output is_data, output data_byte,
                  input ready);
  modport sink (input valid, input req_type, input is_data, input data_byte,
                output ready);
endinterface

interface i2c_dwe_out_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;
  logic busy_res;
  logic accepted;
  logic done_res;

  modport source (output valid, output scl_level, output sda_level, output busy_res,
                  output accepted, output done_res, input ready);
  modport sink (input valid, input scl_level, input sda_level, input busy_res,
                input accepted, input done_res, output ready);
endinterface

>>> design/i2c_display_write_engine_top.sv
// I2C display write engine: write-only I2C master pin sequencer.
//
// Channels: in_ch carries one item per tick or write request (req_type,
// is_data, data_byte); out_ch returns exactly one result item per input
// item (scl_level, sda_level, busy_res, accepted, done_res), in order.
// A write request taken while idle sends start, address byte, control
// byte (command or data), payload byte and stop; each tick item advances
// the bit timing by one tick. Requests that arrive while busy are dropped
// with accepted low.
// Registers on the APB port: slave_address at 0x0, phase_ticks at 0x4.
//
// The result of an item is registered: it sits in the output register in
// the cycle after the item is taken. One item per clock while in_ch.ready is
// high; the sequencer state update is a compare and step per item.
// Stall: while a result waits in the output register and out_ch.ready is
// low, in_ch.ready drops; it stays high whenever the waiting result is
// taken in the same cycle.
// Reset (rst, synchronous): sequencer idle, both lines released, output
// register empty, registers back to address 0x78 and one tick per phase.
module i2c_display_write_engine_top (
  input  logic                                    clk,
  input  logic                                    rst,
  i2c_dwe_in_if.sink                              in_ch,
  i2c_dwe_out_if.source                           out_ch,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [i2c_dwe_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [i2c_dwe_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [i2c_dwe_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                    pready
);
  import i2c_dwe_pkg::*;

  cfg_t  cfg;
  res_t  res_now;
  res_t  res_held;
  logic  out_valid;
  logic  fire;
  logic  cfg_write;
  logic  reg_sel;

  // Accept a new item whenever the output register is free or being drained
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  // APB: no wait states; register picked by word address bit
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= ADDR_RESET;
      cfg.phase_ticks   <= PHASE_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_SLAVE_ADDRESS) begin
        cfg.slave_address <= pwdata[AddrWidth-1:0];
      end else begin
        cfg.phase_ticks <= pwdata[PhaseWidth-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_PHASE_TICKS) begin
      prdata = {{(ApbDataWidth-PhaseWidth){1'b0}}, cfg.phase_ticks};
    end else begin
      prdata = {{(ApbDataWidth-AddrWidth){1'b0}}, cfg.slave_address};
    end
  end

  i2c_dwe_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (fire),
    .req_type  (in_ch.req_type),
    .is_data   (in_ch.is_data),
    .data_byte (in_ch.data_byte),
    .res       (res_now)
  );

  // Output register: load on accept, drop the valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_held <= res_now;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.scl_level = res_held.scl_level;
  assign out_ch.sda_level = res_held.sda_level;
  assign out_ch.busy_res  = res_held.busy_res;
  assign out_ch.accepted  = res_held.accepted;
  assign out_ch.done_res  = res_held.done_res;

endmodule

>>> design/i2c_dwe_seq.sv
module i2c_dwe_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  i2c_dwe_pkg::cfg_t               cfg,
  input  logic                            fire,
  input  logic                            req_type,
  input  logic                            is_data,
  input  logic [i2c_dwe_pkg::ByteWidth-1:0] data_byte,
  output i2c_dwe_pkg::res_t               res
);
  import i2c_dwe_pkg::*;

  seq_step_t             step, step_next;
  logic [TimerWidth-1:0] timer, timer_next;
  logic [1:0]            byte_slot, byte_slot_next;
  logic [3:0]            bit_slot, bit_slot_next;
  logic [ByteWidth-1:0]  shift_reg, shift_reg_next;
  logic [ByteWidth-1:0]  held_byte, held_byte_next;
  logic                  held_is_data, held_is_data_next;
  logic [1:0]            levels, levels_next;

  logic [TimerWidth-1:0] phase_len;
  logic [TimerWidth-1:0] step_len;
  logic [TimerWidth-1:0] timer_inc;
  logic                  busy;
  logic                  ended;

  function automatic logic [1:0] line_levels_f(seq_step_t s, logic [3:0] bslot,
                                               logic [ByteWidth-1:0] sh);
    logic scl;
    logic sda;
    scl = 1'b1;
    sda = 1'b1;
    case (s)
      SEQ_START_B, SEQ_STOP_B: sda = 1'b0;
      SEQ_BIT_LOW, SEQ_BIT_HIGH: begin
        scl = (s == SEQ_BIT_HIGH);
        sda = (bslot < ACK_SLOT) ? sh[ByteWidth-1] : 1'b1;
      end
      SEQ_STOP_A: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      default: ;
    endcase
    return {scl, sda};
  endfunction

  assign busy      = (step != SEQ_IDLE);
  // Zero phase length runs as one tick
  assign phase_len = (cfg.phase_ticks == '0) ? TimerWidth'(1)
                                             : {1'b0, cfg.phase_ticks};
  assign step_len  = (step == SEQ_BIT_LOW || step == SEQ_BIT_HIGH) ? phase_len
                                                                   : (phase_len << 1);
  assign timer_inc = timer + TimerWidth'(1);

  always_comb begin
    step_next         = step;
    timer_next        = timer;
    byte_slot_next    = byte_slot;
    bit_slot_next     = bit_slot;
    shift_reg_next    = shift_reg;
    held_byte_next    = held_byte;
    held_is_data_next = held_is_data;
    levels_next       = levels;
    ended             = 1'b0;

    if (req_type) begin
      if (!busy) begin
        held_byte_next    = data_byte;
        held_is_data_next = is_data;
        shift_reg_next    = cfg.slave_address;
        byte_slot_next    = SLOT_ADDR;
        bit_slot_next     = '0;
        timer_next        = '0;
        step_next         = SEQ_START_A;
      end
    end else if (busy) begin
      timer_next = timer_inc;
      if (timer_inc >= step_len) begin
        timer_next = '0;
        case (step)
          SEQ_START_A: step_next = SEQ_START_B;
          SEQ_START_B: step_next = SEQ_BIT_LOW;
          SEQ_BIT_LOW: step_next = SEQ_BIT_HIGH;
          SEQ_BIT_HIGH: begin
            step_next = SEQ_BIT_LOW;
            if (bit_slot < ACK_SLOT) begin
              shift_reg_next = shift_reg << 1;
              bit_slot_next  = bit_slot + 4'd1;
            end else begin
              // Acknowledge done: load the next byte or head for stop
              bit_slot_next = '0;
              case (byte_slot)
                SLOT_ADDR: begin
                  byte_slot_next = SLOT_CTRL;
                  shift_reg_next = held_is_data ? CTRL_DATA : CTRL_COMMAND;
                end
                SLOT_CTRL: begin
                  byte_slot_next = SLOT_PAYLOAD;
                  shift_reg_next = held_byte;
                end
                default: begin
                  byte_slot_next = SLOT_ADDR;
                  step_next      = SEQ_STOP_A;
                end
              endcase
            end
          end
          SEQ_STOP_A: step_next = SEQ_STOP_B;
          SEQ_STOP_B: step_next = SEQ_STOP_C;
          default: begin
            step_next      = SEQ_IDLE;
            byte_slot_next = SLOT_ADDR;
            bit_slot_next  = '0;
            ended          = 1'b1;
          end
        endcase
      end
    end

    if (step_next != step || shift_reg_next != shift_reg || bit_slot_next != bit_slot) begin
      levels_next = line_levels_f(step_next, bit_slot_next, shift_reg_next);
    end
  end

  // Lines report the levels in force before this item
  always_comb begin
    res.scl_level = levels[1];
    res.sda_level = levels[0];
    res.busy_res  = (step_next != SEQ_IDLE);
    res.accepted  = req_type && !busy;
    res.done_res  = ended;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= SEQ_IDLE;
      timer        <= '0;
      byte_slot    <= SLOT_ADDR;
      bit_slot     <= '0;
      shift_reg    <= '0;
      held_byte    <= '0;
      held_is_data <= 1'b0;
      levels       <= 2'b11;
    end else if (fire) begin
      step         <= step_next;
      timer        <= timer_next;
      byte_slot    <= byte_slot_next;
      bit_slot     <= bit_slot_next;
      shift_reg    <= shift_reg_next;
      held_byte    <= held_byte_next;
      held_is_data <= held_is_data_next;
      levels       <= levels_next;
    end
  end

endmodule
